// File: hdl/assert_macros.svh
// Assertion macros used by the lock arbiter wait queue.
// Depends on nothing; included by the wait queue, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag a condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

// Flag a consequence that fails in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/rwl_pkg.sv
// Shared types and constants of the reader/writer lock arbiter.
// Depends on nothing; imported by the wait queue and the top level.
package rwl_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_ID_BITS     = 8;
   localparam int DEF_MAX_READERS = 255;
   localparam int HOLDING_BITS    = 8;

   typedef enum logic [2:0] {
      CMD_RD_ACQ = 3'd0,
      CMD_RD_TRY = 3'd1,
      CMD_RD_REL = 3'd2,
      CMD_WR_ACQ = 3'd3,
      CMD_WR_TRY = 3'd4,
      CMD_WR_REL = 3'd5
   } rwl_cmd_type;

   typedef enum logic [2:0] {
      EV_GRANTED  = 3'd0,
      EV_QUEUED   = 3'd1,
      EV_TRYFAIL  = 3'd2,
      EV_RELEASED = 3'd3,
      EV_RDWOKEN  = 3'd4,
      EV_WRWOKEN  = 3'd5,
      EV_MISUSE   = 3'd6,
      EV_FULL     = 3'd7
   } rwl_event_type;

   typedef struct packed {
      logic push;
      logic pop;
   } rwl_q_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic one_left;
   } rwl_q_stat_type;

endpackage

// File: hdl/rwl_ram.sv
// Generic single write port RAM with one registered read port.
// Depends on nothing.
module rwl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: hdl/rwl_wait_queue.sv
// FIFO wait queue of requester ids held in one RAM, with head, tail and count.
// Depends on rwl_pkg, rwl_ram and assert_macros.svh.
`include "assert_macros.svh"
module rwl_wait_queue import rwl_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH,
   parameter int WIDTH = DEF_ID_BITS
) (
   input  logic           clock,
   input  logic           reset,
   input  rwl_q_ctl_type  ctl,
   input  logic [WIDTH-1:0] push_id,
   output rwl_q_stat_type status,
   output logic [WIDTH-1:0] head_id
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr);
      return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_comb begin
      head_in  = ctl.pop  ? wrap_inc(head_ff) : head_ff;
      tail_in  = ctl.push ? wrap_inc(tail_ff) : tail_ff;
      count_in = count_ff;
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign status.empty    = (count_ff == '0);
   assign status.full     = (count_ff == CW'(DEPTH));
   assign status.one_left = (count_ff == CW'(1));

   rwl_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (tail_ff),
      .wr_data (push_id),
      .rd_addr (head_in),
      .rd_data (head_id)
   );

   `ASSERT_NEVER(a_pop_empty, clock, reset, ctl.pop && count_ff == '0, "pop on empty queue")
   `ASSERT_NEVER(a_push_full, clock, reset, ctl.push && count_ff == CW'(DEPTH), "push on full queue")
   `ASSERT_NEXT(a_count_up, clock, reset, ctl.push && !ctl.pop, count_ff == $past(count_ff) + 1'b1, "count lost a push")

endmodule

// File: hdl/reader_writer_lock_arbiter_core.sv
// Reader/writer lock arbiter with weak or strong writer preference.
// Each accepted item is registered, then run in S_EXEC, which loads the result
// registers once the output is free; requests stall until it is done. A write
// release that wakes readers answers each from S_WAKE, via the one RAM read port.
// Reset: mode idle, count zero, queues empty by their pointers and counts; no clearing pass.
// Depends on rwl_pkg and rwl_wait_queue.
module reader_writer_lock_arbiter_core import rwl_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = DEF_ID_BITS,
   parameter int MAX_READERS = DEF_MAX_READERS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic [ID_BITS-1:0] req_requester_id,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_event_res,
   output logic [ID_BITS-1:0] rsp_agent_id,
   output logic [HOLDING_BITS-1:0] rsp_readers_holding,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_writer_preference_strong
);

   localparam int CNT_W = $clog2(MAX_READERS + 1);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAKE} state_type;
   typedef enum logic [1:0] {M_IDLE, M_READERS, M_WRITER} mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic [CNT_W-1:0]   rc_ff, rc_in;
   logic               strong_ff, strong_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rwl_event_type      rsp_event_ff, rsp_event_in;
   logic [ID_BITS-1:0] rsp_id_ff, rsp_id_in;
   logic [HOLDING_BITS-1:0] rsp_holding_ff, rsp_holding_in;
   logic               rsp_last_ff, rsp_last_in;

   rwl_q_ctl_type  wq_ctl, rq_ctl;
   rwl_q_stat_type wq_stat, rq_stat;
   logic [ID_BITS-1:0] wq_head, rq_head;

   logic accept, out_free, admissible;
   logic [CNT_W+HOLDING_BITS-1:0] rc_ext;

   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign admissible = (mode_ff != M_WRITER) && (rc_ff < CNT_W'(MAX_READERS))
                       && !(strong_ff && !wq_stat.empty);

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      rc_in          = rc_ff;
      strong_in      = strong_ff;
      cmd_in         = cmd_ff;
      id_in          = id_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_event_in   = rsp_event_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_holding_in = rsp_holding_ff;
      rsp_last_in    = rsp_last_ff;
      wq_ctl         = '0;
      rq_ctl         = '0;

      if (csr_valid && csr_ready) begin
         strong_in = csr_writer_preference_strong;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               id_in    = req_requester_id;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
               case (cmd_ff)
                  CMD_RD_ACQ, CMD_RD_TRY: begin
                     if (admissible) begin
                        rc_in        = rc_ff + 1'b1;
                        mode_in      = M_READERS;
                        rsp_event_in = EV_GRANTED;
                     end else if (cmd_ff == CMD_RD_TRY) begin
                        rsp_event_in = EV_TRYFAIL;
                     end else if (!rq_stat.full) begin
                        rq_ctl.push  = 1'b1;
                        rsp_event_in = EV_QUEUED;
                     end else begin
                        rsp_event_in = EV_FULL;
                     end
                  end
                  CMD_RD_REL: begin
                     if (mode_ff == M_WRITER || rc_ff == '0) begin
                        rsp_event_in = EV_MISUSE;
                     end else begin
                        rc_in        = rc_ff - 1'b1;
                        rsp_event_in = EV_RELEASED;
                        if (rc_ff == CNT_W'(1)) begin
                           mode_in = M_IDLE;
                           if (!wq_stat.empty) begin
                              mode_in      = M_WRITER;
                              wq_ctl.pop   = 1'b1;
                              rsp_event_in = EV_WRWOKEN;
                              rsp_id_in    = wq_head;
                           end
                        end
                     end
                  end
                  CMD_WR_ACQ, CMD_WR_TRY: begin
                     if (mode_ff == M_IDLE && rc_ff == '0) begin
                        mode_in      = M_WRITER;
                        rsp_event_in = EV_GRANTED;
                     end else if (cmd_ff == CMD_WR_TRY) begin
                        rsp_event_in = EV_TRYFAIL;
                     end else if (!wq_stat.full) begin
                        wq_ctl.push  = 1'b1;
                        rsp_event_in = EV_QUEUED;
                     end else begin
                        rsp_event_in = EV_FULL;
                     end
                  end
                  CMD_WR_REL: begin
                     if (mode_ff != M_WRITER) begin
                        rsp_event_in = EV_MISUSE;
                     end else if (!wq_stat.empty) begin
                        wq_ctl.pop   = 1'b1;
                        rsp_event_in = EV_WRWOKEN;
                        rsp_id_in    = wq_head;
                     end else begin
                        mode_in = M_IDLE;
                        if (!rq_stat.empty && rc_ff < CNT_W'(MAX_READERS)) begin
                           rsp_valid_in = rsp_valid_ff && rsp_stall;
                           rsp_id_in    = rsp_id_ff;
                           rsp_last_in  = rsp_last_ff;
                           state_in     = S_WAKE;
                        end else begin
                           rsp_event_in = EV_RELEASED;
                        end
                     end
                  end
                  default: begin
                     rsp_event_in = EV_MISUSE;
                  end
               endcase
            end
         end
         S_WAKE: begin
            if (out_free) begin
               rq_ctl.pop   = 1'b1;
               rc_in        = rc_ff + 1'b1;
               mode_in      = M_READERS;
               rsp_valid_in = 1'b1;
               rsp_event_in = EV_RDWOKEN;
               rsp_id_in    = rq_head;
               rsp_last_in  = rq_stat.one_left || !(rc_ff < CNT_W'(MAX_READERS - 1));
               if (rsp_last_in) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rc_ext = {{HOLDING_BITS{1'b0}}, rc_in};
      if (rsp_valid_in && out_free) begin
         rsp_holding_in = rc_ext[HOLDING_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_IDLE;
         rc_ff        <= '0;
         strong_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rc_ff        <= rc_in;
         strong_ff    <= strong_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      id_ff          <= id_in;
      rsp_event_ff   <= rsp_event_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_holding_ff <= rsp_holding_in;
      rsp_last_ff    <= rsp_last_in;
   end

   rwl_wait_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_BITS)) u_writer_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (wq_ctl),
      .push_id (id_ff),
      .status  (wq_stat),
      .head_id (wq_head)
   );

   rwl_wait_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_BITS)) u_reader_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rq_ctl),
      .push_id (id_ff),
      .status  (rq_stat),
      .head_id (rq_head)
   );

   assign req_stall           = (state_ff != S_IDLE);
   assign csr_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = rsp_event_ff;
   assign rsp_agent_id        = rsp_id_ff;
   assign rsp_readers_holding = rsp_holding_ff;
   assign rsp_last            = rsp_last_ff;

endmodule
